FILE: design/vector_to_euler_angles_defines.svh
// assertion macros for the vector to euler angles design file
`ifndef VECTOR_TO_EULER_ANGLES_DEFINES_SVH
`define VECTOR_TO_EULER_ANGLES_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define VTEA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define VTEA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/vtea_pkg.sv
// types, constants and cordic helper functions for the vector to euler angles block
package vtea_pkg;

   // component and datapath sizing
   localparam int COMPONENT_WIDTH = 16;
   localparam int CORDIC_STAGES   = 16;
   localparam int GUARD_BITS      = 24;
   localparam int DATA_W          = COMPONENT_WIDTH + GUARD_BITS + 5;
   localparam int ACC_W           = 26;
   localparam int Q_W             = ACC_W + 1 - 9;
   localparam int OUT_W           = 16;
   localparam int THR_W           = 15;
   localparam int Z_W             = COMPONENT_WIDTH + 1;
   localparam int GAIN_W          = 18;
   localparam int PROD_W          = Z_W + GAIN_W;
   localparam int CMP_W           = (COMPONENT_WIDTH + 1 > THR_W) ? COMPONENT_WIDTH + 1 : THR_W;
   localparam int REQ_W           = ((3 * COMPONENT_WIDTH + 7) / 8) * 8;
   localparam int RSP_W           = 2 * OUT_W;
   localparam int TABLE_LEN       = 24;
   localparam int STEP_IDX_W      = $clog2(TABLE_LEN);

   // angle constants, accumulator counts 2^-16 degree, output counts 1/128 degree
   localparam int GAIN_Q16    = 107922;
   localparam int FULL_TURN   = 46080;
   localparam int PITCH_UP    = 34560;
   localparam int PITCH_DOWN  = 11520;
   localparam int DEG90_ACC   = 5898240;
   localparam int ROUND_BIAS  = 256;
   localparam int UNIT_SHIFT  = 9;

   // atan(2^-i) in 2^-16 degree
   localparam int ATAN_STEP [TABLE_LEN] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   typedef struct packed {
      data_type x;
      data_type y;
      acc_type  acc;
   } cordic_type;

   // yaw stage: carries the pitch cordic's starting y
   typedef struct packed {
      logic             special;
      logic [OUT_W-1:0] sp_pitch;
      cordic_type       c;
      data_type         pz;
   } yaw_stage_type;

   // pitch stage: carries the finished yaw angle
   typedef struct packed {
      logic             special;
      logic [OUT_W-1:0] sp_pitch;
      cordic_type       c;
      acc_type          yaw_acc;
   } pitch_stage_type;

   // result beat, pitch in the low half
   typedef struct packed {
      logic [OUT_W-1:0] yaw;
      logic [OUT_W-1:0] pitch;
   } result_type;

   // one vectoring micro-rotation
   function automatic cordic_type cordic_iter(cordic_type c, logic [STEP_IDX_W-1:0] idx);
      data_type   xs;
      data_type   ys;
      cordic_type r;
      xs = c.x >>> idx;
      ys = c.y >>> idx;
      if (!c.y[DATA_W-1]) begin
         r.x   = c.x + ys;
         r.y   = c.y - xs;
         r.acc = c.acc + ACC_W'(ATAN_STEP[idx]);
      end else begin
         r.x   = c.x - ys;
         r.y   = c.y + xs;
         r.acc = c.acc - ACC_W'(ATAN_STEP[idx]);
      end
      return r;
   endfunction

   // round half up to 1/128 degree and wrap into one turn
   function automatic logic [OUT_W-1:0] to_units(acc_type a);
      logic signed [ACC_W:0] r;
      logic signed [Q_W-1:0] q;
      r = (ACC_W+1)'(a) + (ACC_W+1)'(ROUND_BIAS);
      q = Q_W'(r >>> UNIT_SHIFT);
      if (q < 0) begin
         q = q + Q_W'(FULL_TURN);
      end
      if (q >= Q_W'(FULL_TURN)) begin
         q = q - Q_W'(FULL_TURN);
      end
      return OUT_W'(q);
   endfunction

endpackage

FILE: design/vector_to_euler_angles.sv
// Throughput: one vector per cycle while not stalled; one entry stage, one stage per yaw
// and per pitch micro-rotation, then an output register backed by a one-beat skid register.
// When the skid register holds a beat the whole pipeline holds and req_tready is low.
// Reset (synchronous, active high) clears all valid bits, the skid and zero_threshold.
module vector_to_euler_angles (
   input  logic                        clock,
   input  logic                        reset,
   // config write: zero_threshold
   input  logic                        csr_wvalid,
   output logic                        csr_wready,
   input  logic [vtea_pkg::THR_W-1:0]  csr_wdata,
   // request: x_component, y_component, z_component (from bit 0 up)
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [vtea_pkg::REQ_W-1:0]  req_tdata,
   // response: pitch_angle, yaw_angle (from bit 0 up)
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [vtea_pkg::RSP_W-1:0]  rsp_tdata
);
   import vtea_pkg::*;
   `include "vector_to_euler_angles_defines.svh"

   localparam int ITERS = CORDIC_STAGES;
   localparam int CW    = COMPONENT_WIDTH;

   logic [THR_W-1:0]  thr_ff;
   logic              adv;
   logic              arrive;

   yaw_stage_type     yaw_ff [0:ITERS];
   yaw_stage_type     yaw_in [0:ITERS];
   logic [ITERS:0]    yv_ff;
   pitch_stage_type   pit_ff [1:ITERS];
   pitch_stage_type   pit_in [1:ITERS];
   logic [ITERS:1]    pv_ff;

   result_type        fin;
   result_type        rsp_ff, rsp_in;
   result_type        skid_ff, skid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              skid_valid_ff, skid_valid_in;

   logic signed [CW-1:0]    x_s, y_s, z_s;
   logic signed [CW:0]      x_e, y_e;
   logic [CW:0]             ax, ay;
   logic                    zero_vec, near_axis;
   data_type                sx, sy;
   logic signed [Z_W-1:0]   nz;
   logic signed [GAIN_W-1:0] gain_s;
   logic signed [PROD_W-1:0] prod;

   // config register
   assign csr_wready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_wvalid && csr_wready) begin
         thr_ff <= csr_wdata;
      end
   end

   // pipeline moves unless the skid register is occupied
   assign adv        = !skid_valid_ff;
   assign req_tready = adv;

   // entry stage: special cases, quadrant fold, scaled pitch start value
   always_comb begin
      x_s = signed'(req_tdata[CW-1:0]);
      y_s = signed'(req_tdata[2*CW-1:CW]);
      z_s = signed'(req_tdata[3*CW-1:2*CW]);
      x_e = (CW+1)'(x_s);
      y_e = (CW+1)'(y_s);
      ax  = x_e[CW] ? unsigned'(-x_e) : unsigned'(x_e);
      ay  = y_e[CW] ? unsigned'(-y_e) : unsigned'(y_e);
      zero_vec  = (x_s == '0) && (y_s == '0) && (z_s == '0);
      near_axis = (CMP_W'(ax) <= CMP_W'(thr_ff)) && (CMP_W'(ay) <= CMP_W'(thr_ff));

      sx = data_type'(x_s) <<< GUARD_BITS;
      sy = data_type'(y_s) <<< GUARD_BITS;

      nz     = -(Z_W'(z_s));
      gain_s = GAIN_W'(GAIN_Q16);
      prod   = nz * gain_s;

      yaw_in[0].special  = zero_vec || near_axis;
      if (zero_vec) begin
         yaw_in[0].sp_pitch = '0;
      end else if (z_s > 0) begin
         yaw_in[0].sp_pitch = OUT_W'(PITCH_UP);
      end else begin
         yaw_in[0].sp_pitch = OUT_W'(PITCH_DOWN);
      end
      yaw_in[0].pz = data_type'(prod) <<< (GUARD_BITS - 16);

      // left half plane: turn by 90 degrees toward positive x; right half plane passes unchanged
      if (!x_s[CW-1]) begin
         yaw_in[0].c.x   = sx;
         yaw_in[0].c.y   = sy;
         yaw_in[0].c.acc = '0;
      end else if (!y_s[CW-1]) begin
         yaw_in[0].c.x   = sy;
         yaw_in[0].c.y   = -sx;
         yaw_in[0].c.acc = ACC_W'(DEG90_ACC);
      end else begin
         yaw_in[0].c.x   = -sy;
         yaw_in[0].c.y   = sx;
         yaw_in[0].c.acc = -ACC_W'(DEG90_ACC);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         yaw_ff[0] <= yaw_in[0];
      end
   end

   // yaw cordic, one micro-rotation per stage
   for (genvar k = 0; k < ITERS; k++) begin : g_yaw
      always_comb begin
         yaw_in[k+1]   = yaw_ff[k];
         yaw_in[k+1].c = cordic_iter(yaw_ff[k].c, STEP_IDX_W'(k));
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            yaw_ff[k+1] <= yaw_in[k+1];
         end
      end
   end

   // pitch cordic, starts from the yaw magnitude and the gain-scaled -z
   for (genvar k = 0; k < ITERS; k++) begin : g_pitch
      if (k == 0) begin : g_first
         always_comb begin
            cordic_type src;
            src.x   = yaw_ff[ITERS].c.x;
            src.y   = yaw_ff[ITERS].pz;
            src.acc = '0;
            pit_in[1].special  = yaw_ff[ITERS].special;
            pit_in[1].sp_pitch = yaw_ff[ITERS].sp_pitch;
            pit_in[1].yaw_acc  = yaw_ff[ITERS].c.acc;
            pit_in[1].c        = cordic_iter(src, STEP_IDX_W'(k));
         end
      end else begin : g_rest
         always_comb begin
            pit_in[k+1]   = pit_ff[k];
            pit_in[k+1].c = cordic_iter(pit_ff[k].c, STEP_IDX_W'(k));
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            pit_ff[k+1] <= pit_in[k+1];
         end
      end
   end

   // valid bits travel alongside the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         yv_ff <= '0;
         pv_ff <= '0;
      end else if (adv) begin
         yv_ff <= {yv_ff[ITERS-1:0], req_tvalid};
         pv_ff <= {pv_ff[ITERS-1:1], yv_ff[ITERS]};
      end
   end

   // final conversion and special-case select
   always_comb begin
      if (pit_ff[ITERS].special) begin
         fin.pitch = pit_ff[ITERS].sp_pitch;
         fin.yaw   = '0;
      end else begin
         fin.pitch = to_units(pit_ff[ITERS].c.acc);
         fin.yaw   = to_units(pit_ff[ITERS].yaw_acc);
      end
   end

   assign arrive = pv_ff[ITERS] && adv;

   // output register with skid
   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!rsp_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (arrive) begin
            rsp_in       = fin;
            rsp_valid_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (arrive) begin
         skid_in       = fin;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // checks
   `VTEA_ASSERT_SAME(a_angle_range, clock, reset, rsp_valid_ff, (rsp_ff.pitch < OUT_W'(FULL_TURN)) && (rsp_ff.yaw < OUT_W'(FULL_TURN)), "angle out of range")
   `VTEA_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff, "skid full with empty output")
   `VTEA_ASSERT_SAME(a_skid_fill, clock, reset, $rose(skid_valid_ff), $past(rsp_valid_ff && !rsp_tready), "skid filled without stall")
   `VTEA_ASSERT_NEXT(a_stall_hold, clock, reset, !adv, $stable(yv_ff) && $stable(pv_ff), "pipeline moved while stalled")

endmodule
